FILE: rtl/text_buffer_cursor_editor_assert.svh
// ----------------------------------------------------------------------------
// Text buffer cursor editor assertion macros
// Shared property wrappers for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef TEXT_BUFFER_CURSOR_EDITOR_ASSERT_SVH
`define TEXT_BUFFER_CURSOR_EDITOR_ASSERT_SVH

// same-cycle implication
`define TBCE_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TBCE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/tbce_pkg.sv
// ----------------------------------------------------------------------------
// tbce_pkg
// Shared constants for the text buffer cursor editor.
// ----------------------------------------------------------------------------
package tbce_pkg;

    localparam int BUFFER_DEPTH = 1024;

    localparam int FUNC_W  = 3;
    localparam int CHAR_W  = 7;
    localparam int IDX_W   = 10;
    localparam int FIELD_W = 11;

    localparam logic [FUNC_W-1:0] FN_INSERT    = 3'd0;
    localparam logic [FUNC_W-1:0] FN_NEWLINE   = 3'd1;
    localparam logic [FUNC_W-1:0] FN_BACKSPACE = 3'd2;
    localparam logic [FUNC_W-1:0] FN_DELETE    = 3'd3;
    localparam logic [FUNC_W-1:0] FN_LEFT      = 3'd4;
    localparam logic [FUNC_W-1:0] FN_RIGHT     = 3'd5;
    localparam logic [FUNC_W-1:0] FN_READ      = 3'd6;

    localparam logic [CHAR_W-1:0] CH_NEWLINE = 7'd10;
    localparam logic [CHAR_W-1:0] CH_LOW     = 7'd32;
    localparam logic [CHAR_W-1:0] CH_HIGH    = 7'd126;

endpackage

FILE: rtl/tbce_ram.sv
// ----------------------------------------------------------------------------
// tbce_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tbce_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/tbce_step_unit.sv
// ----------------------------------------------------------------------------
// tbce_step_unit
// Shared pointer stepper and magnitude compare used by every sweep.
// ----------------------------------------------------------------------------
module tbce_step_unit #(
    parameter int CW = 11
) (
    input  logic [CW-1:0] i_ptr,
    input  logic          i_dec,
    input  logic [CW-1:0] i_cmp_a,
    input  logic [CW-1:0] i_cmp_b,
    output logic [CW-1:0] o_step,
    output logic          o_lt
);

    assign o_step = i_dec ? (i_ptr - CW'(1)) : (i_ptr + CW'(1));
    assign o_lt   = (i_cmp_a < i_cmp_b);

endmodule

FILE: rtl/text_buffer_cursor_editor.sv
// ----------------------------------------------------------------------------
// text_buffer_cursor_editor
// Bounded character buffer with an insertion cursor; one keystroke per
// transfer, cursor row and column rescanned after every command.
// ----------------------------------------------------------------------------
//  channel  handshake           payload
//  in       i_valid / o_ready   i_func, i_char_code, i_read_index
//  out      o_valid / i_ready   o_cursor_col, o_cursor_row, o_text_length,
//                               o_read_char, o_rejected
//
//  Steps: accept, then a tail shift (insert, newline, delete, backspace) or a
//  RAM read (read), then a rescan from buffer start to the new cursor, then
//  the result, held until taken.
//  o_ready is high only while idle; one transfer is worked at a time.
//  Reset clears the length and cursor; buffer contents need no clearing.
//  A held result stalls nothing but the next input transfer.
// ----------------------------------------------------------------------------
module text_buffer_cursor_editor #(
    parameter int BUFFER_DEPTH = tbce_pkg::BUFFER_DEPTH
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [tbce_pkg::FUNC_W-1:0] i_func,
    input  logic [tbce_pkg::CHAR_W-1:0] i_char_code,
    input  logic [tbce_pkg::IDX_W-1:0]  i_read_index,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [tbce_pkg::FIELD_W-1:0] o_cursor_col,
    output logic [tbce_pkg::FIELD_W-1:0] o_cursor_row,
    output logic [tbce_pkg::FIELD_W-1:0] o_text_length,
    output logic [tbce_pkg::CHAR_W-1:0] o_read_char,
    output logic                        o_rejected
);

    localparam int AW = $clog2(BUFFER_DEPTH);
    localparam int CW = $clog2(BUFFER_DEPTH + 1);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_UP    = 4'd1;
    localparam logic [3:0] ST_PUT   = 4'd2;
    localparam logic [3:0] ST_DOWN  = 4'd3;
    localparam logic [3:0] ST_RD    = 4'd4;
    localparam logic [3:0] ST_RD2   = 4'd5;
    localparam logic [3:0] ST_SCAN0 = 4'd6;
    localparam logic [3:0] ST_SCAN  = 4'd7;
    localparam logic [3:0] ST_OUT   = 4'd8;

    logic [3:0]                  r_state, n_state;
    logic [CW-1:0]               r_ptr, n_ptr;
    logic [CW-1:0]               r_cursor, n_cursor;
    logic [CW-1:0]               r_len, n_len;
    logic [CW-1:0]               r_row, n_row;
    logic [CW-1:0]               r_col, n_col;
    logic [AW-1:0]               r_waddr, n_waddr;
    logic                        r_wv, n_wv;
    logic                        r_sv, n_sv;
    logic [tbce_pkg::CHAR_W-1:0] r_char, n_char;
    logic [AW-1:0]               r_ridx, n_ridx;
    logic [tbce_pkg::CHAR_W-1:0] r_rchar, n_rchar;
    logic                        r_rej, n_rej;

    logic                        ram_we;
    logic [AW-1:0]               ram_waddr;
    logic [tbce_pkg::CHAR_W-1:0] ram_wdata;
    logic [AW-1:0]               ram_raddr;
    logic [tbce_pkg::CHAR_W-1:0] ram_rdata;

    logic                        su_dec;
    logic [CW-1:0]               su_cmp_a;
    logic [CW-1:0]               su_cmp_b;
    logic [CW-1:0]               su_step;
    logic                        su_lt;

    logic                        full;
    logic                        bad_char;

    tbce_ram #(
        .WIDTH (tbce_pkg::CHAR_W),
        .DEPTH (BUFFER_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    tbce_step_unit #(
        .CW (CW)
    ) u_step (
        .i_ptr   (r_ptr),
        .i_dec   (su_dec),
        .i_cmp_a (su_cmp_a),
        .i_cmp_b (su_cmp_b),
        .o_step  (su_step),
        .o_lt    (su_lt)
    );

    assign full     = (r_len == CW'(BUFFER_DEPTH));
    assign bad_char = (i_char_code < tbce_pkg::CH_LOW) || (i_char_code > tbce_pkg::CH_HIGH);

    always_comb begin
        n_state   = r_state;
        n_ptr     = r_ptr;
        n_cursor  = r_cursor;
        n_len     = r_len;
        n_row     = r_row;
        n_col     = r_col;
        n_waddr   = r_waddr;
        n_wv      = r_wv;
        n_sv      = r_sv;
        n_char    = r_char;
        n_ridx    = r_ridx;
        n_rchar   = r_rchar;
        n_rej     = r_rej;
        ram_we    = 1'b0;
        ram_waddr = r_waddr;
        ram_wdata = ram_rdata;
        ram_raddr = r_ptr[AW-1:0];
        su_dec    = 1'b0;
        su_cmp_a  = r_ptr;
        su_cmp_b  = r_cursor;

        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_rchar = '0;
                    n_rej   = 1'b0;
                    n_wv    = 1'b0;
                    n_state = ST_SCAN0;
                    unique case (i_func)
                        tbce_pkg::FN_INSERT: begin
                            if (bad_char || full) begin
                                n_rej = 1'b1;
                            end else begin
                                n_char  = i_char_code;
                                n_ptr   = r_len;
                                n_state = ST_UP;
                            end
                        end
                        tbce_pkg::FN_NEWLINE: begin
                            if (full) begin
                                n_rej = 1'b1;
                            end else begin
                                n_char  = tbce_pkg::CH_NEWLINE;
                                n_ptr   = r_len;
                                n_state = ST_UP;
                            end
                        end
                        tbce_pkg::FN_BACKSPACE: begin
                            if (r_cursor != '0) begin
                                n_cursor = r_cursor - CW'(1);
                                n_ptr    = r_cursor - CW'(1);
                                n_state  = ST_DOWN;
                            end
                        end
                        tbce_pkg::FN_DELETE: begin
                            if (r_cursor < r_len) begin
                                n_ptr   = r_cursor;
                                n_state = ST_DOWN;
                            end
                        end
                        tbce_pkg::FN_LEFT: begin
                            if (r_cursor != '0) begin
                                n_cursor = r_cursor - CW'(1);
                            end
                        end
                        tbce_pkg::FN_RIGHT: begin
                            if (r_cursor < r_len) begin
                                n_cursor = r_cursor + CW'(1);
                            end
                        end
                        tbce_pkg::FN_READ: begin
                            if (32'(i_read_index) < 32'(r_len)) begin
                                n_ridx  = AW'(32'(i_read_index));
                                n_state = ST_RD;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_UP: begin
                // tail moves up: read ptr-1, write it at ptr in the next cycle
                su_dec   = 1'b1;
                su_cmp_a = r_cursor;
                su_cmp_b = r_ptr;
                ram_we   = r_wv;
                if (su_lt) begin
                    ram_raddr = su_step[AW-1:0];
                    n_ptr     = su_step;
                    n_waddr   = r_ptr[AW-1:0];
                    n_wv      = 1'b1;
                end else begin
                    n_wv    = 1'b0;
                    n_state = ST_PUT;
                end
            end
            ST_PUT: begin
                ram_we    = 1'b1;
                ram_waddr = r_cursor[AW-1:0];
                ram_wdata = r_char;
                n_cursor  = r_cursor + CW'(1);
                n_len     = r_len + CW'(1);
                n_state   = ST_SCAN0;
            end
            ST_DOWN: begin
                // tail moves down: read ptr+1, write it at ptr
                su_cmp_a = su_step;
                su_cmp_b = r_len;
                ram_we   = r_wv;
                if (su_lt) begin
                    ram_raddr = su_step[AW-1:0];
                    n_ptr     = su_step;
                    n_waddr   = r_ptr[AW-1:0];
                    n_wv      = 1'b1;
                end else begin
                    n_wv    = 1'b0;
                    n_len   = r_len - CW'(1);
                    n_state = ST_SCAN0;
                end
            end
            ST_RD: begin
                ram_raddr = r_ridx;
                n_state   = ST_RD2;
            end
            ST_RD2: begin
                n_rchar = ram_rdata;
                n_state = ST_SCAN0;
            end
            ST_SCAN0: begin
                n_ptr   = '0;
                n_row   = '0;
                n_col   = '0;
                n_sv    = 1'b0;
                n_state = ST_SCAN;
            end
            ST_SCAN: begin
                if (r_sv) begin
                    if (ram_rdata == tbce_pkg::CH_NEWLINE) begin
                        n_row = r_row + CW'(1);
                        n_col = '0;
                    end else begin
                        n_col = r_col + CW'(1);
                    end
                end
                if (su_lt) begin
                    n_ptr = su_step;
                    n_sv  = 1'b1;
                end else begin
                    n_sv = 1'b0;
                    if (!r_sv) begin
                        n_state = ST_OUT;
                    end
                end
            end
            ST_OUT: begin
                if (i_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_cursor <= '0;
            r_len    <= '0;
            r_wv     <= 1'b0;
            r_sv     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cursor <= n_cursor;
            r_len    <= n_len;
            r_wv     <= n_wv;
            r_sv     <= n_sv;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr   <= n_ptr;
        r_row   <= n_row;
        r_col   <= n_col;
        r_waddr <= n_waddr;
        r_char  <= n_char;
        r_ridx  <= n_ridx;
        r_rchar <= n_rchar;
        r_rej   <= n_rej;
    end

    assign o_ready       = (r_state == ST_IDLE);
    assign o_valid       = (r_state == ST_OUT);
    assign o_cursor_col  = tbce_pkg::FIELD_W'(32'(r_col));
    assign o_cursor_row  = tbce_pkg::FIELD_W'(32'(r_row));
    assign o_text_length = tbce_pkg::FIELD_W'(32'(r_len));
    assign o_read_char   = r_rchar;
    assign o_rejected    = r_rej;

endmodule

FILE: rtl/tbce_checker.sv
// ----------------------------------------------------------------------------
// tbce_checker
// Port-level checks for the text buffer cursor editor, bound to the top.
// ----------------------------------------------------------------------------
`include "text_buffer_cursor_editor_assert.svh"

module tbce_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_valid,
    input logic                         o_ready,
    input logic                         o_valid,
    input logic                         i_ready,
    input logic [tbce_pkg::FIELD_W-1:0] o_cursor_col,
    input logic [tbce_pkg::FIELD_W-1:0] o_text_length,
    input logic [tbce_pkg::CHAR_W-1:0]  o_read_char
);

    `TBCE_ASSERT_NEXT(a_out_hold, o_valid && !i_ready, o_valid && $stable(o_cursor_col) && $stable(o_text_length), "stalled result changed")

    `TBCE_ASSERT_NEXT(a_busy_after_accept, i_valid && o_ready, !o_ready && !o_valid, "not busy after input transfer")

    `TBCE_ASSERT_SAME(a_one_item, o_valid, !o_ready, "input taken while result pending")

    `TBCE_ASSERT_SAME(a_char_legal, o_valid, (o_read_char == 7'd0) || (o_read_char == tbce_pkg::CH_NEWLINE) || ((o_read_char >= tbce_pkg::CH_LOW) && (o_read_char <= tbce_pkg::CH_HIGH)), "read returned an unstorable code")

endmodule

bind text_buffer_cursor_editor tbce_checker u_tbce_checker (.*);
